>>> sv/pcds_pkg.sv
// Package: command and status codes, FSM state type for the distribution sampler.
`timescale 1ns / 1ps
package pcds_pkg;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_WAIT,
		S_FETCH,
		S_DIVIDE,
		S_DONE
	} state_t;

	localparam int FRAC_BITS = 16;

endpackage

>>> sv/pcds_divider.sv
// Restoring bit-serial divider: floor(numer / denom), one quotient bit per cycle.
`timescale 1ns / 1ps
module pcds_divider #(
	parameter int NUM_BITS = 32,
	parameter int DEN_BITS = 26,
	parameter int QUO_BITS = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] numer,
	input  logic [DEN_BITS-1:0] denom,
	output logic                done,
	output logic [QUO_BITS-1:0] quotient
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS+1:0] trial;
	logic [DEN_BITS:0]   shifted;

	// Shift in the next numerator bit and try the subtract
	assign shifted = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, shifting numerator and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
			if (!trial[DEN_BITS+1]) begin
				rem_q <= trial[DEN_BITS:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q[QUO_BITS-1:0];

endmodule

>>> sv/piecewise_constant_distribution_sample.sv
// Top level: weight table with prefix sums, inverse-CDF sampler and probability divider.
`timescale 1ns / 1ps
// One request at a time. Start, append and unused commands present their result the
// cycle after the request is accepted. A sample runs a binary search with one read of
// the prefix memory per step (a SEARCH and a WAIT state each, at most
// ceil(log2(count+1)) steps), one read of the weight memory and a bit-serial divide of
// the WEIGHT_BITS+16-bit numerator. Zero-total and empty-table samples finish like the
// other commands. The next request is taken once the result has been accepted.
// Weights and prefix sums live in two single-port synchronous memories; only entries
// below the entry count are ever used, so no clearing pass is needed after reset.
module piecewise_constant_distribution_sample #(
	parameter int MAX_ENTRIES = 1024,
	parameter int WEIGHT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [1:0]  command,
	input  logic [15:0] weight,
	input  logic [15:0] uniform_fraction,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [10:0] index,
	output logic [16:0] probability,
	output logic [1:0]  status
);
	localparam int ADDR_BITS = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_BITS  = WEIGHT_BITS + CNT_BITS;
	localparam int PRD_BITS  = SUM_BITS + pcds_pkg::FRAC_BITS;
	localparam int NUM_BITS  = WEIGHT_BITS + pcds_pkg::FRAC_BITS;
	localparam int WIN_BITS  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

	pcds_pkg::state_t state_q, state_d;

	logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
	logic [SUM_BITS-1:0]    prefix_mem [MAX_ENTRIES];
	logic [WEIGHT_BITS-1:0] wrd_q;
	logic [SUM_BITS-1:0]    prd_q;

	logic [CNT_BITS-1:0] count_q;
	logic [SUM_BITS-1:0] total_q;
	logic [CNT_BITS-1:0] lo_q, hi_q;
	logic [PRD_BITS-1:0] target_q;
	logic [CNT_BITS-1:0] mid;
	logic [WEIGHT_BITS-1:0] wmask;
	logic [SUM_BITS-1:0] total_new;

	logic        out_vld_q;
	logic [10:0] idx_q;
	logic [16:0] prob_q;
	logic [1:0]  stat_q;

	logic                div_start, div_done;
	logic [16:0]         div_quo;
	logic [NUM_BITS-1:0] div_num;

	logic accept;
	logic [CNT_BITS+15:0] upick;

	assign accept   = valid_in && ready_in;
	assign ready_in = (state_q == pcds_pkg::S_IDLE) && !out_vld_q;
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign wmask    = WEIGHT_BITS'(weight[WIN_BITS-1:0]);
	assign total_new = total_q + SUM_BITS'(wmask);
	assign upick    = {{CNT_BITS{1'b0}}, uniform_fraction} * {16'd0, count_q};

	// Memories: append writes both, search reads prefix, fetch reads weight
	always_ff @(posedge clk) begin
		if (accept && command == pcds_pkg::CMD_APPEND && count_q < CNT_BITS'(MAX_ENTRIES)) begin
			weight_mem[count_q[ADDR_BITS-1:0]] <= wmask;
			prefix_mem[count_q[ADDR_BITS-1:0]] <= total_new;
		end else begin
			prd_q <= prefix_mem[mid[ADDR_BITS-1:0]];
			wrd_q <= weight_mem[lo_q[ADDR_BITS-1:0]];
		end
	end

	// Next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			pcds_pkg::S_IDLE: begin
				if (accept && command == pcds_pkg::CMD_SAMPLE && count_q != '0
				    && total_q != '0)
					state_d = pcds_pkg::S_SEARCH;
			end
			pcds_pkg::S_SEARCH: begin
				if (lo_q >= hi_q) state_d = pcds_pkg::S_FETCH;
				else              state_d = pcds_pkg::S_WAIT;
			end
			pcds_pkg::S_WAIT:   state_d = pcds_pkg::S_SEARCH;
			pcds_pkg::S_FETCH:  state_d = pcds_pkg::S_DIVIDE;
			pcds_pkg::S_DIVIDE: begin
				div_start = 1'b1;
				state_d   = pcds_pkg::S_DONE;
			end
			pcds_pkg::S_DONE: begin
				if (div_done) state_d = pcds_pkg::S_IDLE;
			end
			default: state_d = pcds_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pcds_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// Control: table state, search bounds, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			out_vld_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
		end else begin
			if (out_vld_q && ready_out) out_vld_q <= 1'b0;
			if (accept) begin
				case (command)
					pcds_pkg::CMD_START: begin
						count_q <= '0;
						total_q <= '0;
						out_vld_q <= 1'b1;
					end
					pcds_pkg::CMD_APPEND: begin
						if (count_q < CNT_BITS'(MAX_ENTRIES)) begin
							count_q <= count_q + 1'b1;
							total_q <= total_new;
						end
						out_vld_q <= 1'b1;
					end
					pcds_pkg::CMD_SAMPLE: begin
						lo_q <= '0;
						hi_q <= count_q;
						if (count_q == '0 || total_q == '0) out_vld_q <= 1'b1;
					end
					default: out_vld_q <= 1'b1;
				endcase
			end
			if (state_q == pcds_pkg::S_WAIT) begin
				if ({prd_q, 16'd0} <= target_q) lo_q <= mid + 1'b1;
				else                            hi_q <= mid;
			end
			if (state_q == pcds_pkg::S_SEARCH && lo_q >= hi_q && lo_q >= count_q)
				lo_q <= count_q - 1'b1;
			if (state_q == pcds_pkg::S_DONE && div_done) out_vld_q <= 1'b1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= PRD_BITS'(uniform_fraction) * PRD_BITS'(total_q);
			prob_q   <= '0;
			case (command)
				pcds_pkg::CMD_START: begin
					idx_q  <= '0;
					stat_q <= pcds_pkg::ST_OK;
				end
				pcds_pkg::CMD_APPEND: begin
					if (count_q < CNT_BITS'(MAX_ENTRIES)) begin
						idx_q  <= 11'(count_q + 1'b1);
						stat_q <= pcds_pkg::ST_OK;
					end else begin
						idx_q  <= 11'(count_q);
						stat_q <= pcds_pkg::ST_FULL;
					end
				end
				pcds_pkg::CMD_SAMPLE: begin
					if (count_q == '0) begin
						idx_q  <= '0;
						stat_q <= pcds_pkg::ST_EMPTY;
					end else begin
						idx_q  <= 11'(upick[CNT_BITS+15:16]);
						stat_q <= (total_q == '0) ? pcds_pkg::ST_ZERO : pcds_pkg::ST_OK;
					end
				end
				default: begin
					idx_q  <= 11'(count_q);
					stat_q <= pcds_pkg::ST_OK;
				end
			endcase
		end
		if (state_q == pcds_pkg::S_FETCH) idx_q <= 11'(lo_q);
		if (state_q == pcds_pkg::S_DONE && div_done) prob_q <= div_quo;
	end

	assign div_num = {wrd_q, 16'd0};

	pcds_divider #(
		.NUM_BITS(NUM_BITS),
		.DEN_BITS(SUM_BITS),
		.QUO_BITS(17)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_num),
		.denom    (total_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign valid_out   = out_vld_q;
	assign index       = idx_q;
	assign probability = prob_q;
	assign status      = stat_q;

	// Checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != pcds_pkg::S_IDLE |-> !ready_in) else $error("accept while busy");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ENTRIES)) else $error("entry count overflow");
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcds_pkg::S_FETCH |-> lo_q < count_q) else $error("index past table");
	a_prob_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> probability <= 17'h10000) else $error("probability above one");

endmodule
